@@ rtl/acalc_pkg.sv @@
// ----------------------------------------------------------------------------
// acalc_pkg
// Shared types and constants for the ASCII expression calculator.
// ----------------------------------------------------------------------------
package acalc_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned ErrW  = 2;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharStar  = 8'h2A;
  localparam logic [CharW-1:0] CharSlash = 8'h2F;
  localparam logic [DataW-1:0] AsciiZero = 32'd48;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK          = 2'd0,
    ERR_DIV_ZERO    = 2'd1,
    ERR_NO_OPERATOR = 2'd2
  } err_e;

  // controller to datapath
  typedef struct packed {
    logic accum;
    logic div_start;
    logic load_out;
  } acalc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_busy;
  } acalc_sts_t;

endpackage

@@ rtl/acalc_char_if.sv @@
// ----------------------------------------------------------------------------
// acalc_char_if
// Input channel: one ASCII byte per item plus a terminator flag.
// ----------------------------------------------------------------------------
interface acalc_char_if import acalc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_byte;
  logic             end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

@@ rtl/acalc_result_if.sv @@
// ----------------------------------------------------------------------------
// acalc_result_if
// Output channel: signed result and error code per item.
// ----------------------------------------------------------------------------
interface acalc_result_if import acalc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_value;
  logic [ErrW-1:0]         error_code;

  modport source (output valid, output result_value, output error_code, input ready);
  modport sink   (input valid, input result_value, input error_code, output ready);
endinterface

@@ rtl/ascii_expression_calculator_core.sv @@
// ----------------------------------------------------------------------------
// ascii_expression_calculator_core
// Four-function integer calculator over a line of ASCII bytes.
// ----------------------------------------------------------------------------
// an operand or operator byte is accumulated on acceptance; a terminator leads to
// the done state, for a nonzero divide via the one-bit-per-cycle divider; the result
// register lets bytes of the next line in while it waits
// reset (asynchronous, active low) clears the operands, operator and handshakes
module ascii_expression_calculator_core import acalc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  acalc_char_if.sink     char_i,
  acalc_result_if.source result_o
);

  acalc_cmd_t cmd;
  acalc_sts_t sts;

  acalc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (char_i.valid),
    .end_of_line_i (char_i.end_of_line),
    .in_ready_o    (char_i.ready),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  acalc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_byte_i    (char_i.char_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (result_o.result_value),
    .error_code_o   (result_o.error_code)
  );

endmodule

@@ rtl/acalc_div.sv @@
// ----------------------------------------------------------------------------
// acalc_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module acalc_div import acalc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DataW-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  assign trial = {rem_q, quo_q[DataW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d  = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ rtl/acalc_datapath.sv @@
// ----------------------------------------------------------------------------
// acalc_datapath
// Operand accumulation, operator latch, arithmetic and output payload.
// ----------------------------------------------------------------------------
module acalc_datapath import acalc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CharW-1:0]        char_byte_i,
  input  acalc_cmd_t              cmd_i,
  output acalc_sts_t              sts_o,
  output logic signed [DataW-1:0] result_value_o,
  output logic [ErrW-1:0]         error_code_o
);

  logic             second_q, second_d;
  op_e              op_q, op_d;
  logic [DataW-1:0] first_q, first_d;
  logic [DataW-1:0] opb_q, opb_d;
  logic [DataW-1:0] res_q, res_d;
  err_e             err_q, err_d;
  logic [DataW-1:0] acc_sel;
  logic [DataW-1:0] acc_next;
  logic [DataW-1:0] quotient;
  logic             div_busy;
  logic             is_op;
  op_e              char_op;

  acalc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (first_q),
    .divisor_i  (opb_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    is_op   = 1'b1;
    char_op = OP_ADD;
    unique case (char_byte_i)
      CharPlus:  char_op = OP_ADD;
      CharMinus: char_op = OP_SUB;
      CharStar:  char_op = OP_MUL;
      CharSlash: char_op = OP_DIV;
      default:   is_op   = 1'b0;
    endcase
  end

  // acc * 10 + (byte - 48)
  assign acc_sel  = second_q ? opb_q : first_q;
  assign acc_next = (acc_sel << 3) + (acc_sel << 1)
                  + ({{(DataW-CharW){1'b0}}, char_byte_i} - AsciiZero);

  always_comb begin
    second_d = second_q;
    op_d     = op_q;
    first_d  = first_q;
    opb_d    = opb_q;
    res_d    = res_q;
    err_d    = err_q;
    if (cmd_i.load_out) begin
      err_d = ERR_OK;
      res_d = '0;
      if (!second_q) begin
        err_d = ERR_NO_OPERATOR;
      end else begin
        unique case (op_q)
          OP_ADD: res_d = first_q + opb_q;
          OP_SUB: res_d = first_q - opb_q;
          OP_MUL: res_d = first_q * opb_q;
          OP_DIV: begin
            if (opb_q == '0) begin
              err_d = ERR_DIV_ZERO;
            end else begin
              res_d = quotient;
            end
          end
          default: res_d = '0;
        endcase
      end
      second_d = 1'b0;
      op_d     = OP_ADD;
      first_d  = '0;
      opb_d    = '0;
    end else if (cmd_i.accum) begin
      if (second_q) begin
        opb_d = acc_next;
      end else if (is_op) begin
        op_d     = char_op;
        second_d = 1'b1;
      end else begin
        first_d = acc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      op_q     <= OP_ADD;
      first_q  <= '0;
      opb_q    <= '0;
    end else begin
      second_q <= second_d;
      op_q     <= op_d;
      first_q  <= first_d;
      opb_q    <= opb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= err_d;
  end

  assign sts_o.div_needed = second_q && (op_q == OP_DIV) && (opb_q != '0);
  assign sts_o.div_busy   = div_busy;
  assign result_value_o   = res_q;
  assign error_code_o     = err_q;

endmodule

@@ rtl/acalc_ctrl.sv @@
// ----------------------------------------------------------------------------
// acalc_ctrl
// Line controller: accepts bytes, sequences the divide, hands off results.
// ----------------------------------------------------------------------------
module acalc_ctrl import acalc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       end_of_line_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output acalc_cmd_t cmd_o,
  input  acalc_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.accum     = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!end_of_line_i) begin
            cmd_o.accum = 1'b1;
          end else if (sts_i.div_needed) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ dv/tb_ascii_expression_calculator_core.sv @@
// ----------------------------------------------------------------------------
// tb_ascii_expression_calculator_core
// Self-checking bench for the ASCII calculator: lines of bytes go in through
// a queued driver, a predictor computes each line's result on acceptance and
// a monitor compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ascii_expression_calculator_core;
  import acalc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned QuietTail  = 80;
  localparam int unsigned DrainWait  = 60;

  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             end_of_line;
  } char_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    err_e                    err;
  } calc_result_t;

  logic clk_i;
  logic rst_ni;

  acalc_char_if   char_if ();
  acalc_result_if res_if ();

  ascii_expression_calculator_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_if),
    .result_o (res_if)
  );

  char_item_t   pending_chars[$];
  calc_result_t expected_results[$];

  // predicted calculator state
  logic             pred_in_second;
  logic [DataW-1:0] pred_first;
  logic [DataW-1:0] pred_second;
  op_e              pred_op;

  int unsigned n_lines, n_checked, n_mismatch;
  int unsigned n_op[4];
  int unsigned n_div_zero, n_no_op;

  function automatic logic quiet();
    return (pending_chars.size() < QuietTail);
  endfunction

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [DataW-1:0] quot_trunc(logic [DataW-1:0] a, logic [DataW-1:0] b);
    logic [DataW-1:0] ma, mb, q;
    ma = a[DataW-1] ? (-a) : a;
    mb = b[DataW-1] ? (-b) : b;
    q  = ma / mb;
    return (a[DataW-1] ^ b[DataW-1]) ? (-q) : q;
  endfunction

  function automatic logic [DataW-1:0] digit_step(logic [DataW-1:0] acc, logic [CharW-1:0] b);
    return acc * 32'd10 + ({{(DataW-CharW){1'b0}}, b} - AsciiZero);
  endfunction

  // advance the predicted state by one accepted item
  task automatic predict_char(input char_item_t it);
    calc_result_t r;
    if (it.end_of_line) begin
      r.value = '0;
      r.err   = ERR_OK;
      if (!pred_in_second) begin
        r.err = ERR_NO_OPERATOR;
        n_no_op++;
      end else begin
        n_op[pred_op]++;
        case (pred_op)
          OP_ADD: r.value = pred_first + pred_second;
          OP_SUB: r.value = pred_first - pred_second;
          OP_MUL: r.value = pred_first * pred_second;
          default: begin
            if (pred_second == '0) begin
              r.err = ERR_DIV_ZERO;
              n_div_zero++;
            end else begin
              r.value = quot_trunc(pred_first, pred_second);
            end
          end
        endcase
      end
      expected_results.push_back(r);
      n_lines++;
      pred_in_second = 1'b0;
      pred_first     = '0;
      pred_second    = '0;
      pred_op        = OP_ADD;
    end else if (!pred_in_second) begin
      if (it.char_byte == CharPlus) begin
        pred_op = OP_ADD;
        pred_in_second = 1'b1;
      end else if (it.char_byte == CharMinus) begin
        pred_op = OP_SUB;
        pred_in_second = 1'b1;
      end else if (it.char_byte == CharStar) begin
        pred_op = OP_MUL;
        pred_in_second = 1'b1;
      end else if (it.char_byte == CharSlash) begin
        pred_op = OP_DIV;
        pred_in_second = 1'b1;
      end else begin
        pred_first = digit_step(pred_first, it.char_byte);
      end
    end else begin
      pred_second = digit_step(pred_second, it.char_byte);
    end
  endtask

  // driver
  int unsigned send_gap, send_calm;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.valid       <= 1'b0;
      char_if.char_byte   <= '0;
      char_if.end_of_line <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
      pred_in_second = 1'b0;
      pred_first     = '0;
      pred_second    = '0;
      pred_op        = OP_ADD;
    end else begin : drive
      logic       nxt_valid;
      char_item_t it;
      nxt_valid = char_if.valid;
      if (char_if.valid && char_if.ready) begin
        it.char_byte   = char_if.char_byte;
        it.end_of_line = char_if.end_of_line;
        predict_char(it);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_calm > 0) send_calm--;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet() && send_calm == 0 && $urandom_range(0, 39) == 0) begin
          send_calm = $urandom_range(30, 120);
        end else if (!quiet() && send_calm == 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
        end else if (pending_chars.size() != 0) begin
          it = pending_chars.pop_front();
          char_if.char_byte   <= it.char_byte;
          char_if.end_of_line <= it.end_of_line;
          nxt_valid = 1'b1;
        end
      end
      char_if.valid <= nxt_valid;
    end
  end

  // monitor
  int unsigned recv_gap, recv_calm;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap  = 0;
      recv_calm = 0;
    end else begin : watch
      logic         nxt_ready;
      calc_result_t e;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, value %0d error %0d", $time,
                   res_if.result_value, res_if.error_code);
          n_mismatch++;
        end else begin
          e = expected_results.pop_front();
          n_checked++;
          if (res_if.result_value !== e.value) begin
            $display("%0t: result_value mismatch, expected %0d actual %0d", $time,
                     e.value, res_if.result_value);
            n_mismatch++;
          end
          if (res_if.error_code !== e.err) begin
            $display("%0t: error_code mismatch, expected %0d actual %0d", $time,
                     e.err, res_if.error_code);
            n_mismatch++;
          end
        end
      end
      if (recv_calm > 0) recv_calm--;
      if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else if (!quiet() && recv_calm == 0 && $urandom_range(0, 39) == 0) begin
        recv_calm = $urandom_range(30, 120);
        nxt_ready = 1'b1;
      end else if (!quiet() && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
        recv_gap  = $urandom_range(0, 17);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      res_if.ready <= nxt_ready;
    end
  end

  // watchdog
  int unsigned stall_cycles;
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_char(input logic [CharW-1:0] b, input logic eol);
    char_item_t it;
    it.char_byte   = b;
    it.end_of_line = eol;
    pending_chars.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  // terminator byte content is ignored, so make it random
  task automatic push_eol();
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic push_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  function automatic int unsigned operand_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 7) return $urandom_range(1, 3);
    return $urandom_range(4, 12);
  endfunction

  task automatic push_random_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned kind;
    logic [CharW-1:0] op_char;
    rst_ni = 1'b0;
    stall_cycles = 0;
    n_lines = 0;
    n_checked = 0;
    n_mismatch = 0;
    n_div_zero = 0;
    n_no_op = 0;
    foreach (n_op[i]) n_op[i] = 0;

    // byte extremes in both operands
    push_char(8'hFF, 1'b0);
    push_char(CharPlus, 1'b0);
    push_char(8'h00, 1'b0);
    push_eol();
    // most negative over minus one, operator byte inside second operand
    push_text("2147483648//");
    push_eol();
    // empty second operand
    push_text("5*");
    push_eol();
    // divide by zero
    push_text("8/");
    push_eol();
    // subtract with an operator character as a digit
    push_text("3--");
    push_eol();
    // missing operator
    push_eol();

    while (pending_chars.size() < 730) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: op_char = CharPlus;
        1: op_char = CharMinus;
        2: op_char = CharStar;
        default: op_char = CharSlash;
      endcase
      if (kind < 72) begin
        push_digits(operand_len());
        push_char(op_char, 1'b0);
        push_digits(operand_len());
      end else if (kind < 82) begin
        push_random_bytes($urandom_range(0, 3));
        push_digits($urandom_range(0, 2));
        push_char(op_char, 1'b0);
        push_random_bytes($urandom_range(0, 3));
        push_digits($urandom_range(0, 2));
      end else if (kind < 90) begin
        push_digits($urandom_range(0, 5));
      end else begin
        push_random_bytes($urandom_range(0, 8));
      end
      push_eol();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || char_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("lines %0d, results checked %0d: add %0d sub %0d mul %0d div %0d",
             n_lines, n_checked, n_op[OP_ADD], n_op[OP_SUB], n_op[OP_MUL], n_op[OP_DIV]);
    $display("divide by zero %0d, missing operator %0d, mismatches %0d",
             n_div_zero, n_no_op, n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/acalc_pkg.sv
rtl/acalc_char_if.sv
rtl/acalc_result_if.sv
rtl/acalc_div.sv
rtl/acalc_datapath.sv
rtl/acalc_ctrl.sv
rtl/ascii_expression_calculator_core.sv
dv/tb_ascii_expression_calculator_core.sv
